// ----- rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

  // screen geometry defaults
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 20;

  // field widths
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int COLOR_W  = 8;
  localparam int CELL_W   = 16;
  localparam int OFFS_W   = 11;

  // stream payload widths, padded to whole bytes
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUT_CHAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LINE_FEED = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ_CELL = 2'd3;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_DRAIN
  } state_t;

endpackage

// ----- rtl/tcw_ram.sv -----
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = tcw_pkg::CELL_W,
  parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/text_console_writer_unit.sv -----
`timescale 1ns / 1ps

// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+-----------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser: action; tdata: char, row, col
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: cursor_offset, cell_value
// cfg       | in        | cfg_valid / cfg_ready         | cfg_data: write_color
//
// a character write and a line feed that stays on screen end in IDLE; read_cell goes via READ
// a scroll sweeps the store once, one read/write pair per cycle; DRAIN writes the last cell
// clear sweeps the store once (one cell write per cycle)
// after reset a clearing pass zeroes the store, no input taken meanwhile
// the result register lets a new transfer in while the result is being taken; a stalled
// result holds the input off otherwise

module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tcw_pkg::S_DATA_W-1:0]  s_axis_tdata,  // char_code[7:0], cell_row[12:8],
                                                       // cell_column[19:13], zero pad
  input  logic [tcw_pkg::ACTION_W-1:0]  s_axis_tuser,  // action[1:0]
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tcw_pkg::M_DATA_W-1:0]  m_axis_tdata,  // cursor_offset[10:0],
                                                       // cell_value[26:11], zero pad
  // color register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COPY_CNT = CELLS - COLUMNS;        // cells moved up by a scroll
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int CELL_W = tcw_pkg::CELL_W;
  localparam int OFFS_W = tcw_pkg::OFFS_W;

  // unpacked input fields
  logic [tcw_pkg::ACTION_W-1:0] in_action;
  logic [tcw_pkg::CHAR_W-1:0]   in_char;
  logic [ROW_W-1:0]             in_row;
  logic [COL_W-1:0]             in_col;

  assign in_action = s_axis_tuser;
  assign in_char   = s_axis_tdata[7:0];
  assign in_row    = s_axis_tdata[12:8];
  assign in_col    = s_axis_tdata[19:13];

  tcw_pkg::state_t state, state_next;

  // configuration
  logic [tcw_pkg::COLOR_W-1:0] write_color;

  // cursor, with the linear cell address kept alongside so no multiply is needed
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [ADDR_W-1:0] cur_addr, cur_addr_next;

  // sweep counter for init, clear and scroll
  logic [ADDR_W-1:0] cnt;

  // scroll write stage: the cell read in the previous cycle lands one row up
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;
  logic              pend_copy;

  // read_cell bookkeeping
  logic              rd_ok;
  logic              rd_ok_next;
  logic [ADDR_W-1:0] read_idx;

  // memory port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // result register
  logic              accept;
  logic              load;
  logic [CELL_W-1:0] load_cell;
  logic [OFFS_W-1:0] out_offset;
  logic [CELL_W-1:0] out_cell;
  logic              cursor_upd;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign read_idx  = ADDR_W'(in_row * COLUMNS) + ADDR_W'(in_col);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // cursor after a line feed, or after a write that wraps
  logic              at_last_row;
  logic              at_last_col;
  logic [ADDR_W-1:0] next_row_addr;

  assign at_last_row   = (cur_row == ROW_W'(ROWS - 1));
  assign at_last_col   = (cur_col == COL_W'(COLUMNS - 1));
  assign next_row_addr = cur_addr - ADDR_W'(cur_col) + ADDR_W'(COLUMNS);

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cnt;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = read_idx;
    load          = 1'b0;
    load_cell     = '0;
    cursor_upd    = 1'b0;
    cur_col_next  = cur_col;
    cur_row_next  = cur_row;
    cur_addr_next = cur_addr;
    rd_ok_next    = rd_ok;

    // scroll write stage owns the write port while it is active
    if (pend_valid) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr;
      ram_wdata = pend_copy ? ram_rdata : '0;
    end

    unique case (state)
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
        if (cnt == ADDR_W'(CELLS - 1)) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        s_axis_tready = !m_axis_tvalid || m_axis_tready;
        if (accept) begin
          unique case (in_action)
            tcw_pkg::ACT_PUT_CHAR: begin
              ram_we     = 1'b1;
              ram_waddr  = cur_addr;
              ram_wdata  = {write_color, in_char};
              cursor_upd = 1'b1;
              if (!at_last_col) begin
                cur_col_next  = cur_col + COL_W'(1);
                cur_addr_next = cur_addr + ADDR_W'(1);
                load          = 1'b1;
              end else if (!at_last_row) begin
                cur_col_next  = '0;
                cur_row_next  = cur_row + ROW_W'(1);
                cur_addr_next = next_row_addr;
                load          = 1'b1;
              end else begin
                cur_col_next  = '0;
                cur_addr_next = ADDR_W'(LAST_ROW_BASE);
                state_next    = tcw_pkg::ST_SCROLL;
              end
            end
            tcw_pkg::ACT_LINE_FEED: begin
              cursor_upd   = 1'b1;
              cur_col_next = '0;
              if (!at_last_row) begin
                cur_row_next  = cur_row + ROW_W'(1);
                cur_addr_next = next_row_addr;
                load          = 1'b1;
              end else begin
                cur_addr_next = ADDR_W'(LAST_ROW_BASE);
                state_next    = tcw_pkg::ST_SCROLL;
              end
            end
            tcw_pkg::ACT_CLEAR: begin
              cursor_upd    = 1'b1;
              cur_col_next  = '0;
              cur_row_next  = '0;
              cur_addr_next = '0;
              state_next    = tcw_pkg::ST_CLEAR;
            end
            tcw_pkg::ACT_READ_CELL: begin
              ram_re     = 1'b1;
              ram_raddr  = read_idx;
              rd_ok_next = (32'(in_row) < ROWS) && (32'(in_col) < COLUMNS);
              state_next = tcw_pkg::ST_READ;
            end
            default: begin
              state_next = tcw_pkg::ST_IDLE;
            end
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        load       = 1'b1;
        load_cell  = rd_ok ? ram_rdata : '0;
        state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = {write_color, tcw_pkg::BLANK_CHAR};
        if (cnt == ADDR_W'(CELLS - 1)) begin
          load       = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (cnt < ADDR_W'(COPY_CNT)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt + ADDR_W'(COLUMNS);
        end
        if (cnt == ADDR_W'(CELLS - 1)) begin
          state_next = tcw_pkg::ST_DRAIN;
        end
      end
      tcw_pkg::ST_DRAIN: begin
        // last cell of the scroll is written here
        load       = 1'b1;
        state_next = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_color   <= tcw_pkg::COLOR_RESET;
      cur_col       <= '0;
      cur_row       <= '0;
      cur_addr      <= '0;
      cnt           <= '0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      rd_ok         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        write_color <= cfg_data;
      end
      if (cursor_upd) begin
        cur_col  <= cur_col_next;
        cur_row  <= cur_row_next;
        cur_addr <= cur_addr_next;
      end
      rd_ok <= rd_ok_next;

      // sweep counter restarts on every entry to a sweep
      if (state == tcw_pkg::ST_IDLE) begin
        cnt <= '0;
      end else if (state == tcw_pkg::ST_INIT || state == tcw_pkg::ST_CLEAR ||
                   state == tcw_pkg::ST_SCROLL) begin
        cnt <= cnt + ADDR_W'(1);
      end

      pend_valid <= (state == tcw_pkg::ST_SCROLL);

      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_addr <= cnt;
    pend_copy <= (cnt < ADDR_W'(COPY_CNT));
    if (load) begin
      out_offset <= OFFS_W'(cur_addr_next);
      out_cell   <= load_cell;
    end
  end

  assign m_axis_tdata = {{(tcw_pkg::M_DATA_W - OFFS_W - CELL_W){1'b0}}, out_cell, out_offset};

  // cursor stays on screen and its linear address tracks row and column
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_col) < COLUMNS) && (32'(cur_row) < ROWS))
    else $error("cursor left the screen");

  a_cursor_addr: assert property (@(posedge clk) disable iff (rst)
    32'(cur_addr) == 32'(cur_row) * COLUMNS + 32'(cur_col))
    else $error("cursor address out of step with row and column");

  // no item taken while the result register is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input taken while result stalled");

  // scroll write stage only runs inside a scroll
  a_pend_in_scroll: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == tcw_pkg::ST_SCROLL || state == tcw_pkg::ST_DRAIN))
    else $error("scroll write outside a scroll");

  // a scroll ends with exactly one result
  a_drain_result: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_DRAIN) |=> (m_axis_tvalid && state == tcw_pkg::ST_IDLE))
    else $error("scroll finished without a result");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int COLUMNS = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS    = tcw_pkg::ROWS_DEF;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ACTION_W = tcw_pkg::ACTION_W;
  localparam int CHAR_W   = tcw_pkg::CHAR_W;
  localparam int ROW_W    = tcw_pkg::ROW_W;
  localparam int COL_W    = tcw_pkg::COL_W;
  localparam int COLOR_W  = tcw_pkg::COLOR_W;
  localparam int CELL_W   = tcw_pkg::CELL_W;
  localparam int OFFS_W   = tcw_pkg::OFFS_W;
  localparam int S_DATA_W = tcw_pkg::S_DATA_W;
  localparam int M_DATA_W = tcw_pkg::M_DATA_W;

  // random part stops once this many input transfers have gone in
  localparam int ITEM_TARGET  = 500;
  // receiver hold-off used to fill the block up
  localparam int HOLD_CYCLES  = 200;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OFFS_W-1:0] cursor_offset;
    logic [CELL_W-1:0] cell_value;
  } console_report_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic [ACTION_W-1:0] s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [COLOR_W-1:0]  cfg_data;

  // predictor state: own copy of the cell store, cursor and color
  logic [CELL_W-1:0]  shadow_cells [CELLS];
  int                 cur_col;
  int                 cur_row;
  logic [COLOR_W-1:0] shadow_color;

  // reports waiting for their output transfer
  console_report_t pending_reports [$];

  int fail_count = 0;
  int items_sent;
  // idle chances in percent, changed from phase to phase
  int send_gap_pct;
  int sink_stall_pct;
  // bumped each time the sink is asked to hold off for a long stretch
  int hold_requests;

  text_console_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous cap, well above the slowest legal run
  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len(int pct);
    if ($urandom_range(99, 0) >= pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // ---------------------------------------------------------------- predictor

  // cursor to column 0 of the next row, scroll up when on the last row
  task automatic advance_line();
    cur_col = 0;
    if (cur_row >= ROWS - 1) begin
      cur_row = ROWS - 1;
      for (int i = 0; i < COLUMNS * (ROWS - 1); i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
      // the row that comes in is all zero cells, not blanks
      for (int i = COLUMNS * (ROWS - 1); i < CELLS; i++) shadow_cells[i] = '0;
    end else begin
      cur_row++;
    end
  endtask

  task automatic predict_console(input logic [ACTION_W-1:0] action, input logic [CHAR_W-1:0] ch,
                                 input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    console_report_t rep;
    rep.cell_value = '0;
    case (action)
      tcw_pkg::ACT_PUT_CHAR: begin
        shadow_cells[cur_row * COLUMNS + cur_col] = {shadow_color, ch};
        cur_col++;
        if (cur_col >= COLUMNS) advance_line();
      end
      tcw_pkg::ACT_LINE_FEED: begin
        advance_line();
      end
      tcw_pkg::ACT_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_color, tcw_pkg::BLANK_CHAR};
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
        // reads off the screen return zero and leave everything alone
        if (int'(row) < ROWS && int'(col) < COLUMNS)
          rep.cell_value = shadow_cells[int'(row) * COLUMNS + int'(col)];
      end
    endcase
    rep.cursor_offset = OFFS_W'(cur_row * COLUMNS + cur_col);
    pending_reports.push_back(rep);
  endtask

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    console_report_t exp_rep;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: output transfer with nothing pending, tdata %h", $realtime,
                   m_axis_tdata);
      end else begin
        exp_rep = pending_reports.pop_front();
        if (m_axis_tdata[OFFS_W-1:0] !== exp_rep.cursor_offset ||
            m_axis_tdata[OFFS_W+CELL_W-1:OFFS_W] !== exp_rep.cell_value) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: mismatch cursor_offset exp %0d got %0d, cell_value exp %h got %h",
                     $realtime, exp_rep.cursor_offset, m_axis_tdata[OFFS_W-1:0],
                     exp_rep.cell_value, m_axis_tdata[OFFS_W+CELL_W-1:OFFS_W]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sink

  // ready changes at the falling edge only, one assignment per step
  initial begin
    int n;
    int holds_done;
    m_axis_tready = 1'b0;
    holds_done    = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        // long hold-off so the result register fills and the input stalls
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
        m_axis_tready = 1'b1;
      end else begin
        n = idle_len(sink_stall_pct);
        if (n > 0) begin
          m_axis_tready = 1'b0;
          repeat (n) @(negedge clk);
        end
        m_axis_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- driver tasks
  // every task starts and ends at a falling edge

  task automatic send_item(input logic [ACTION_W-1:0] action, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    int gap;
    gap = idle_len(send_gap_pct);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  = action;
    s_axis_tdata  = {4'b0, col, row, ch};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_console(action, ch, row, col);
    items_sent++;
    @(negedge clk);
    // valid stays high here, the next call or drain_results decides
  endtask

  // unused fields carry random bits so every bit toggles
  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(tcw_pkg::ACT_PUT_CHAR, ch, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic put_control(input logic [ACTION_W-1:0] action);
    send_item(action, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic read_back(input int row, input int col);
    send_item(tcw_pkg::ACT_READ_CELL, CHAR_W'($urandom), ROW_W'(row), COL_W'(col));
  endtask

  // stop offering and wait until every pending report has come out
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic set_color(input logic [COLOR_W-1:0] color);
    cfg_data  = color;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    shadow_color = color;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // store is zero after the clearing pass; reads off the screen give zero
  task automatic test_reset_contents();
    read_back(0, 0);
    read_back(ROWS - 1, COLUMNS - 1);
    read_back(ROWS, 0);
    read_back(0, COLUMNS);
    read_back(31, 127);
    drain_results();
  endtask

  // character byte lands unchanged under the reset color, top bit never spreads
  task automatic test_char_bytes();
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h80);
    put_char(8'h7F);
    for (int c = 0; c < 4; c++) read_back(0, c);
    drain_results();
  endtask

  // color register at both extremes
  task automatic test_color_extremes();
    set_color(8'hFF);
    put_char(8'h41);
    read_back(0, 4);
    drain_results();
    set_color(8'h00);
    put_char(8'hC3);
    read_back(0, 5);
    drain_results();
  endtask

  // line feed, then clear fills blanks in the current color and homes the cursor
  task automatic test_line_feed_and_clear();
    set_color(8'h1E);
    put_control(tcw_pkg::ACT_LINE_FEED);
    put_char(8'h5A);
    read_back(1, 0);
    put_control(tcw_pkg::ACT_CLEAR);
    read_back(0, 0);
    read_back(ROWS - 1, COLUMNS - 1);
    read_back(1, 0);
    drain_results();
  endtask

  // walk to the last row, scroll, then run a line past the row end on the last row
  task automatic test_wrap_and_scroll();
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    for (int i = 0; i < ROWS; i++) put_control(tcw_pkg::ACT_LINE_FEED);
    read_back(ROWS - 1, 0);
    for (int i = 0; i < COLUMNS + 5; i++) put_char(CHAR_W'($urandom));
    for (int c = 0; c < 6; c++) read_back(ROWS - 1, c);
    read_back(ROWS - 2, COLUMNS - 1);
    read_back(ROWS - 2, 0);
    drain_results();
  endtask

  // sender keeps offering while the receiver holds off for a long stretch
  task automatic test_backpressure();
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    hold_requests++;
    for (int i = 0; i < 40; i++) put_char(CHAR_W'($urandom));
    read_back(cur_row, 0);
    drain_results();
  endtask

  // segments of text lines, reads, line feed runs, the odd clear and the odd color change, idle mix per segment
  task automatic test_random_mix();
    int kind;
    int n;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(3, 0))
        0:       send_gap_pct = 0;
        1:       send_gap_pct = 20;
        default: send_gap_pct = 60;
      endcase
      case ($urandom_range(3, 0))
        0:       sink_stall_pct = 0;
        1:       sink_stall_pct = 20;
        default: sink_stall_pct = 60;
      endcase
      kind = $urandom_range(99, 0);
      if (kind < 45) begin
        // a line of text, sometimes long enough to wrap
        n = ($urandom_range(3, 0) == 0) ? $urandom_range(COLUMNS + 20, COLUMNS - 10)
                                        : $urandom_range(30, 1);
        for (int i = 0; i < n; i++) begin
          put_char(CHAR_W'($urandom));
          if ($urandom_range(7, 0) == 0) read_back(cur_row, $urandom_range(COLUMNS - 1, 0));
        end
        if ($urandom_range(9, 0) < 7) put_control(tcw_pkg::ACT_LINE_FEED);
      end else if (kind < 75) begin
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(3, 0) == 0)
            read_back($urandom_range(31, 0), $urandom_range(127, 0));
          else
            read_back($urandom_range(ROWS - 1, 0), $urandom_range(COLUMNS - 1, 0));
        end
      end else if (kind < 88) begin
        // a run of line feeds, at times long enough to reach the bottom and scroll
        n = $urandom_range(ROWS + 4, 1);
        for (int i = 0; i < n; i++) put_control(tcw_pkg::ACT_LINE_FEED);
      end else if (kind < 94) begin
        put_control(tcw_pkg::ACT_CLEAR);
      end else begin
        drain_results();
        set_color(COLOR_W'($urandom));
      end
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = tcw_pkg::ACT_PUT_CHAR;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    items_sent     = 0;
    send_gap_pct   = 20;
    sink_stall_pct = 20;
    hold_requests  = 0;
    cur_col        = 0;
    cur_row        = 0;
    shadow_color   = tcw_pkg::COLOR_RESET;
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_contents();
    test_char_bytes();
    test_color_extremes();
    test_line_feed_and_clear();
    test_wrap_and_scroll();
    test_backpressure();
    test_random_mix();

    // room for any stray output transfer to show up
    repeat (20) @(negedge clk);

    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
